### design/bltg_pkg.sv
// bltg_pkg: shared types and constants for the bouncing line trail generator
// no dependencies; used by every module of the block by scoped names

package bltg_pkg;

	// sizes of the trail memory and the palette
	localparam int RING_DEPTH   = 64;
	localparam int PALETTE_SIZE = 256;

	// the trail is stored one line (two points) per memory word
	localparam int RING_PAIRS = RING_DEPTH / 2;
	localparam int PAIR_W     = (RING_PAIRS > 1) ? $clog2(RING_PAIRS) : 1;
	localparam int CNT_W      = $clog2(RING_PAIRS + 1);
	localparam int PS_W       = ($clog2(RING_DEPTH + 1) > 7) ? $clog2(RING_DEPTH + 1) : 7;
	localparam int PAL_W      = $clog2(PALETTE_SIZE);

	// field widths
	localparam int COORD_W = 14;
	localparam int VEL_W   = 8;
	localparam int RAND_W  = 31;
	localparam int REM_W   = 12;

	// remainder units retire this many dividend bits per cycle
	localparam int DIGITS_PER_STEP = 4;
	localparam int DIV_STEPS       = 32 / DIGITS_PER_STEP;
	localparam int DIV_CNT_W       = $clog2(DIV_STEPS);

	// lane count: four speed words and four start position words
	localparam int LANES = 8;

	// configuration register indexes
	localparam logic [2:0] CFG_SCREEN_WIDTH  = 3'd0;
	localparam logic [2:0] CFG_SCREEN_HEIGHT = 3'd1;
	localparam logic [2:0] CFG_SPEED_SPAN    = 3'd2;
	localparam logic [2:0] CFG_SPEED_BASE    = 3'd3;
	localparam logic [2:0] CFG_POINT_SLOTS   = 3'd4;
	localparam logic [2:0] CFG_COLOR_COUNT   = 3'd5;
	localparam logic [2:0] CFG_MONO_MODE     = 3'd6;

	// input command codes
	localparam logic CMD_STEP  = 1'b0;
	localparam logic CMD_START = 1'b1;

	// one remembered line: first point then second point
	typedef struct packed {
		logic [COORD_W-1:0] x0;
		logic [COORD_W-1:0] y0;
		logic [COORD_W-1:0] x1;
		logic [COORD_W-1:0] y1;
	} line_t;

	// trail memory request
	typedef struct packed {
		logic              rd_en;
		logic [PAIR_W-1:0] rd_addr;
		logic              wr_en;
		logic [PAIR_W-1:0] wr_addr;
		logic              clear;
	} ring_req_t;

	// remainder lane control
	typedef struct packed {
		logic load;
		logic run;
	} lane_ctl_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_UPD  = 3'b100
	} state_t;

endpackage

### design/bouncing_line_trail_generator_unit.sv
// bouncing_line_trail_generator_unit: top level, sequencer, endpoint state
// depends on bltg_pkg, bltg_mod_lane and bltg_trail_ring
//
// Each input beat passes through the sequencer states in order: ST_IDLE accepts
// the beat and reads the oldest line from the trail memory, ST_DIV runs the
// remainder lanes (four bits of each 31-bit random word per cycle, eight
// lanes side by side), and ST_UPD moves the endpoints, writes the new line
// back and loads the output register. A start beat gives no result; a step
// beat gives one. The next beat is accepted while a result still waits in
// the output register, but the update of that next step waits until the
// register is free. The trail memory needs no clearing pass after reset or
// start. Configuration writes must be made while the block is idle.

module bouncing_line_trail_generator_unit (
	input  logic         clk,
	input  logic         arst_n,
	// input stream
	input  logic         s_tvalid,
	output logic         s_tready,
	// rand_vx_a, rand_vy_a, rand_vx_b, rand_vy_b,
	// rand_px_a, rand_py_a, rand_px_b, rand_py_b (31 bits each)
	input  logic [247:0] s_tdata,
	// command
	input  logic         s_tuser,
	// output stream
	output logic         m_tvalid,
	input  logic         m_tready,
	// erase_x0, erase_y0, erase_x1, erase_y1, draw_x0, draw_y0,
	// draw_x1, draw_y1 (14 bits each), color_index (8 bits)
	output logic [119:0] m_tdata,
	// use_white
	output logic         m_tuser,
	// configuration writes
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [11:0]  cfg_data
);

	localparam int CW = bltg_pkg::COORD_W;
	localparam int VW = bltg_pkg::VEL_W;

	// configuration registers
	logic [11:0] screen_width_q;
	logic [11:0] screen_height_q;
	logic [6:0]  speed_span_q;
	logic [5:0]  speed_base_q;
	logic [6:0]  point_slots_q;
	logic [8:0]  color_count_q;
	logic        mono_mode_q;

	// block state
	bltg_pkg::state_t                 state_q;
	logic [bltg_pkg::DIV_CNT_W-1:0]   div_cnt_q;
	logic                             cmd_q;
	logic [CW-1:0]                    pos_q [4];
	logic [VW-1:0]                    vel_q [4];
	logic [bltg_pkg::PAIR_W-1:0]      wp_q;
	logic [bltg_pkg::PAL_W-1:0]       pal_q;

	// output register
	logic         m_tvalid_q;
	logic [119:0] m_tdata_q;
	logic         m_tuser_q;

	// lanes and trail memory
	bltg_pkg::lane_ctl_t              lane_ctl;
	logic [bltg_pkg::REM_W-1:0]       lane_div [bltg_pkg::LANES];
	logic [bltg_pkg::REM_W-1:0]       lane_rem [bltg_pkg::LANES];
	bltg_pkg::ring_req_t              ring_req;
	bltg_pkg::line_t                  wr_line;
	bltg_pkg::line_t                  rd_line;

	// derived control
	logic                             s_accept;
	logic                             out_free;
	logic                             upd_go;
	logic [bltg_pkg::PS_W-1:0]        ps_ext;
	logic [bltg_pkg::CNT_W-1:0]       pairs;
	logic [bltg_pkg::PAIR_W-1:0]      wp_eff;
	logic [bltg_pkg::CNT_W-1:0]       wp_inc;
	logic [bltg_pkg::PAIR_W-1:0]      first_p;
	logic [6:0]                       span_eff;
	logic [11:0]                      lim [4];
	logic [CW-1:0]                    pos_n [4];
	logic [VW-1:0]                    vel_n [4];
	logic [CW-1:0]                    start_pos [4];
	logic [VW-1:0]                    speed [4];
	logic                             colored;
	logic [8:0]                       pal_lim;
	logic [bltg_pkg::PAL_W-1:0]       pal_use;
	logic [8:0]                       pal_inc;
	logic [bltg_pkg::PAL_W-1:0]       pal_next;

	assign s_accept = s_tvalid && s_tready;
	assign s_tready = (state_q == bltg_pkg::ST_IDLE);
	assign out_free = !m_tvalid_q || m_tready;
	assign upd_go   = (state_q == bltg_pkg::ST_UPD) && ((cmd_q == bltg_pkg::CMD_START) || out_free);

	// configuration write port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q  <= 12'd1280;
			screen_height_q <= 12'd1024;
			speed_span_q    <= 7'd16;
			speed_base_q    <= 6'd5;
			point_slots_q   <= 7'd64;
			color_count_q   <= 9'd256;
			mono_mode_q     <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				bltg_pkg::CFG_SCREEN_WIDTH:  screen_width_q  <= cfg_data;
				bltg_pkg::CFG_SCREEN_HEIGHT: screen_height_q <= cfg_data;
				bltg_pkg::CFG_SPEED_SPAN:    speed_span_q    <= cfg_data[6:0];
				bltg_pkg::CFG_SPEED_BASE:    speed_base_q    <= cfg_data[5:0];
				bltg_pkg::CFG_POINT_SLOTS:   point_slots_q   <= cfg_data[6:0];
				bltg_pkg::CFG_COLOR_COUNT:   color_count_q   <= cfg_data[8:0];
				bltg_pkg::CFG_MONO_MODE:     mono_mode_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// line count in use and trail pointers
	always_comb begin
		ps_ext = bltg_pkg::PS_W'(point_slots_q);
		if (ps_ext >= bltg_pkg::PS_W'(bltg_pkg::RING_DEPTH))
			pairs = bltg_pkg::CNT_W'(bltg_pkg::RING_PAIRS);
		else if (ps_ext < bltg_pkg::PS_W'(2))
			pairs = bltg_pkg::CNT_W'(1);
		else
			pairs = bltg_pkg::CNT_W'(ps_ext >> 1);
		wp_eff  = (bltg_pkg::CNT_W'(wp_q) >= pairs) ? '0 : wp_q;
		wp_inc  = bltg_pkg::CNT_W'(wp_eff) + bltg_pkg::CNT_W'(1);
		first_p = (wp_inc == pairs) ? '0 : bltg_pkg::PAIR_W'(wp_inc);
	end

	// speed modulus clamped to one through 64
	always_comb begin
		if (speed_span_q == 7'd0)
			span_eff = 7'd1;
		else if (speed_span_q > 7'd64)
			span_eff = 7'd64;
		else
			span_eff = speed_span_q;
	end

	// lane divisors: speed words first, then start position words
	always_comb begin
		lim[0] = screen_width_q;
		lim[1] = screen_height_q;
		lim[2] = screen_width_q;
		lim[3] = screen_height_q;
		for (int c = 0; c < 4; c++) begin
			lane_div[c]     = {5'd0, span_eff};
			lane_div[c + 4] = lim[c];
		end
	end

	assign lane_ctl.load = s_accept;
	assign lane_ctl.run  = (state_q == bltg_pkg::ST_DIV);

	// remainder lanes
	for (genvar g = 0; g < bltg_pkg::LANES; g++) begin : g_lane
		bltg_mod_lane u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (lane_ctl),
			.dividend (s_tdata[g*bltg_pkg::RAND_W +: bltg_pkg::RAND_W]),
			.divisor  (lane_div[g]),
			.rem      (lane_rem[g])
		);
	end

	// endpoint motion, bounce and start values
	always_comb begin
		for (int c = 0; c < 4; c++) begin
			speed[c]     = {1'b0, {1'b0, lane_rem[c][5:0]} + {1'b0, speed_base_q}};
			start_pos[c] = (lim[c] == 12'd0) ? '0 : {2'b00, lane_rem[c + 4]};
			pos_n[c]     = pos_q[c] + {{(CW - VW){vel_q[c][VW-1]}}, vel_q[c]};
			if (pos_n[c][CW-1])
				vel_n[c] = speed[c];
			else if ($signed(pos_n[c]) > $signed({2'b00, lim[c]}))
				vel_n[c] = -speed[c];
			else
				vel_n[c] = vel_q[c];
		end
	end

	// palette cycling
	always_comb begin
		colored  = !mono_mode_q && (color_count_q > 9'd2);
		pal_lim  = (color_count_q > 9'(bltg_pkg::PALETTE_SIZE)) ?
			9'(bltg_pkg::PALETTE_SIZE) : color_count_q;
		pal_use  = (9'(pal_q) >= pal_lim) ? '0 : pal_q;
		pal_inc  = 9'(pal_use) + 9'd1;
		pal_next = (pal_inc >= pal_lim) ? '0 : bltg_pkg::PAL_W'(pal_inc);
	end

	// trail memory access: read the oldest line on accept, write back on a step update, clear on a start
	always_comb begin
		ring_req.rd_en   = s_accept;
		ring_req.rd_addr = first_p;
		ring_req.wr_en   = upd_go && (cmd_q == bltg_pkg::CMD_STEP);
		ring_req.wr_addr = wp_eff;
		ring_req.clear   = upd_go && (cmd_q == bltg_pkg::CMD_START);
		wr_line.x0       = pos_n[0];
		wr_line.y0       = pos_n[1];
		wr_line.x1       = pos_n[2];
		wr_line.y1       = pos_n[3];
	end

	bltg_trail_ring u_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (ring_req),
		.wr_line (wr_line),
		.rd_line (rd_line)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= bltg_pkg::ST_IDLE;
			div_cnt_q <= '0;
		end else begin
			case (state_q)
				bltg_pkg::ST_IDLE: begin
					div_cnt_q <= '0;
					if (s_accept)
						state_q <= bltg_pkg::ST_DIV;
				end
				bltg_pkg::ST_DIV: begin
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == bltg_pkg::DIV_CNT_W'(bltg_pkg::DIV_STEPS - 1))
						state_q <= bltg_pkg::ST_UPD;
				end
				bltg_pkg::ST_UPD: begin
					if (upd_go)
						state_q <= bltg_pkg::ST_IDLE;
				end
				default: state_q <= bltg_pkg::ST_IDLE;
			endcase
		end
	end

	// command of the beat in flight
	always_ff @(posedge clk) begin
		if (s_accept)
			cmd_q <= s_tuser;
	end

	// endpoint, velocity, pointer and palette state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < 4; c++) begin
				pos_q[c] <= '0;
				vel_q[c] <= '0;
			end
			wp_q  <= '0;
			pal_q <= '0;
		end else if (upd_go) begin
			if (cmd_q == bltg_pkg::CMD_START) begin
				for (int c = 0; c < 4; c++) begin
					pos_q[c] <= start_pos[c];
					vel_q[c] <= speed[c];
				end
				wp_q  <= '0;
				pal_q <= '0;
			end else begin
				for (int c = 0; c < 4; c++) begin
					pos_q[c] <= pos_n[c];
					vel_q[c] <= vel_n[c];
				end
				wp_q <= first_p;
				if (colored)
					pal_q <= pal_next;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (upd_go && (cmd_q == bltg_pkg::CMD_STEP)) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (upd_go && (cmd_q == bltg_pkg::CMD_STEP)) begin
			m_tdata_q <= {colored ? 8'(pal_use) : 8'd0,
				pos_n[3], pos_n[2], pos_n[1], pos_n[0],
				rd_line.y1, rd_line.x1, rd_line.y0, rd_line.x0};
			m_tuser_q <= !colored;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// the trail write stays inside the lines in use
	a_wr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ring_req.wr_en |-> (bltg_pkg::CNT_W'(ring_req.wr_addr) < pairs))
		else $error("trail write beyond the lines in use");

	// a start leaves the trail pointer and palette position at zero
	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(upd_go && (cmd_q == bltg_pkg::CMD_START)) |=> (wp_q == '0) && (pal_q == '0))
		else $error("start did not clear the trail pointer or palette");

	// a step result never overwrites a beat that was not taken
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == bltg_pkg::ST_UPD) && (cmd_q == bltg_pkg::CMD_STEP) && !out_free)
		|=> (state_q == bltg_pkg::ST_UPD))
		else $error("update left while the output beat was pending");

	// a new result appears only right after an update
	a_valid_from_update: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> ($past(state_q) == bltg_pkg::ST_UPD))
		else $error("output beat raised outside an update");

endmodule

### design/bltg_mod_lane.sv
// bltg_mod_lane: restoring remainder unit, several dividend bits per cycle
// depends on bltg_pkg for widths and the lane control struct

module bltg_mod_lane (
	input  logic                       clk,
	input  logic                       arst_n,
	input  bltg_pkg::lane_ctl_t        ctl,
	input  logic [bltg_pkg::RAND_W-1:0] dividend,
	input  logic [bltg_pkg::REM_W-1:0]  divisor,
	output logic [bltg_pkg::REM_W-1:0]  rem
);

	logic [31:0]                  num_q;
	logic [bltg_pkg::REM_W-1:0]   div_q;
	logic [bltg_pkg::REM_W-1:0]   rem_q;
	logic [bltg_pkg::REM_W-1:0]   rem_n;
	logic [bltg_pkg::REM_W:0]     part;

	// shift in the next dividend bits, subtract where the divisor fits
	always_comb begin
		part = {1'b0, rem_q};
		for (int i = 0; i < bltg_pkg::DIGITS_PER_STEP; i++) begin
			part = {part[bltg_pkg::REM_W-1:0], num_q[31-i]};
			if (part >= {1'b0, div_q})
				part = part - {1'b0, div_q};
		end
		rem_n = part[bltg_pkg::REM_W-1:0];
	end

	// operand and partial remainder registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (ctl.load) begin
			rem_q <= '0;
		end else if (ctl.run) begin
			rem_q <= rem_n;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			num_q <= {1'b0, dividend};
			div_q <= divisor;
		end else if (ctl.run) begin
			num_q <= {num_q[31-bltg_pkg::DIGITS_PER_STEP:0], {bltg_pkg::DIGITS_PER_STEP{1'b0}}};
		end
	end

	assign rem = rem_q;

endmodule

### design/bltg_trail_ring.sv
// bltg_trail_ring: trail memory, one line per word, registered read
// depends on bltg_pkg; valid bits make unwritten lines read as zero points

module bltg_trail_ring (
	input  logic                clk,
	input  logic                arst_n,
	input  bltg_pkg::ring_req_t req,
	input  bltg_pkg::line_t     wr_line,
	output bltg_pkg::line_t     rd_line
);

	bltg_pkg::line_t                 mem [bltg_pkg::RING_PAIRS];
	logic [bltg_pkg::RING_PAIRS-1:0] valid_q;
	bltg_pkg::line_t                 rdata_q;
	logic                            rvalid_q;

	// memory write port
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= wr_line;
		end
	end

	// memory read port
	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rdata_q <= mem[req.rd_addr];
		end
	end

	// per-line valid bits, cleared on reset and on start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (req.clear) begin
				valid_q <= '0;
			end else if (req.wr_en) begin
				valid_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				rvalid_q <= valid_q[req.rd_addr];
			end
		end
	end

	assign rd_line = rvalid_q ? rdata_q : '0;

endmodule
